// ===== rtl/cfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock frequency monitor package
// Shared widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package cfm_pkg;

	// Field and register widths
	localparam int COUNT_W    = 32;
	localparam int REF_IN_W   = 28;
	localparam int PRESCALE_W = 16;
	localparam int TPS_W      = 10;
	localparam int IVL_W      = 8;
	localparam int HZ_W       = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int FACTOR_W   = PRESCALE_W + TPS_W;
	localparam int PROD_W     = COUNT_W + FACTOR_W;
	localparam int CNT_W      = $clog2(HZ_W);

	// Parameter defaults
	localparam int WINDOW_LOG2_DEF    = 4;
	localparam int REF_COUNT_BITS_DEF = 28;

	// Register reset values
	localparam logic [COUNT_W-1:0]    MASK_RST     = COUNT_W'(32'h00FF_FFFF);
	localparam logic [PRESCALE_W-1:0] PRESCALE_RST = PRESCALE_W'(1);
	localparam logic [TPS_W-1:0]      TPS_RST      = TPS_W'(100);
	localparam logic [IVL_W-1:0]      IVL_MAX_RST  = IVL_W'(1);

	// Interval adaptation thresholds on the probe difference
	localparam logic [COUNT_W-1:0] DELTA_LOW  = COUNT_W'(4000);
	localparam logic [COUNT_W-1:0] DELTA_HIGH = COUNT_W'(40000);

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PROBE_MASK = 2'd0,
		REG_PRESCALE   = 2'd1,
		REG_TPS        = 2'd2,
		REG_IVL_MAX    = 2'd3
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_UPD  = 8'b0000_0010,
		ST_MHI  = 8'b0000_0100,
		ST_MLO  = 8'b0000_1000,
		ST_ADD  = 8'b0001_0000,
		ST_SAT  = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

endpackage

// ===== rtl/clock_frequency_monitor.sv =====
// An item runs ST_UPD, then ST_MHI, ST_MLO, ST_ADD, ST_SAT and ST_DIV once for the probe
// and once for the reference, on the shared multiplier and a 32-step restoring divider
// (one quotient bit per cycle). ST_DONE offers the result; items are taken only in ST_IDLE.
// Reset (arst_n low, asynchronous) restores the register defaults, clears the
// history window, sums and last snapshots, and sets the interval to one.
// ----------------------------------------------------------------------------
// Clock frequency monitor
// Moving-window frequency estimate of a probe and a reference counter, with
// an adaptive sampling interval.
// ----------------------------------------------------------------------------
module clock_frequency_monitor
	import cfm_pkg::*;
#(
	parameter int WINDOW_LOG2    = WINDOW_LOG2_DEF,
	parameter int REF_COUNT_BITS = REF_COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [COUNT_W-1:0]    cfg_wdata,
	// Input items
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [63:0]           s_axis_tdata,   // probe_count[31:0], ref_count[59:32], zero pad
	// Result items
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [103:0]          m_axis_tdata    // probe_freq, ref_hz, probe_delta, interval
);

	localparam int WIN  = 1 << WINDOW_LOG2;
	localparam int RB   = REF_COUNT_BITS;
	localparam int PSW  = COUNT_W + WINDOW_LOG2;
	localparam int RSW  = RB + WINDOW_LOG2;

	// Configuration registers
	logic [COUNT_W-1:0]    mask_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic [TPS_W-1:0]      tps_q;
	logic [IVL_W-1:0]      ivl_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= MASK_RST;
			prescale_q <= PRESCALE_RST;
			tps_q      <= TPS_RST;
			ivl_max_q  <= IVL_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PROBE_MASK: mask_q     <= cfg_wdata;
				REG_PRESCALE:   prescale_q <= cfg_wdata[PRESCALE_W-1:0];
				REG_TPS:        tps_q      <= cfg_wdata[TPS_W-1:0];
				REG_IVL_MAX:    ivl_max_q  <= cfg_wdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Window state
	state_t                   state_q;
	logic [COUNT_W-1:0]       pc_q;
	logic [RB-1:0]            rc_q;
	logic [COUNT_W-1:0]       probe_last_q;
	logic [RB-1:0]            ref_last_q;
	logic [COUNT_W-1:0]       probe_hist_q [WIN];
	logic [RB-1:0]            ref_hist_q [WIN];
	logic [PSW-1:0]           probe_sum_q;
	logic [RSW-1:0]           ref_sum_q;
	logic [WINDOW_LOG2-1:0]   slot_q;
	logic [IVL_W-1:0]         ivl_q;

	// Arithmetic sequencer registers
	logic                     ch_q;
	logic [FACTOR_W-1:0]      factor_q;
	logic [PROD_W-1:0]        prod_q;
	logic [PROD_W-1:0]        acc_q;
	logic                     sat_q;
	logic [IVL_W-1:0]         rem_q;
	logic [HZ_W-1:0]          qd_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [HZ_W-1:0]          probe_freq_q;
	logic [HZ_W-1:0]          ref_hz_q;
	logic [COUNT_W-1:0]       pd_q;

	// Output register
	logic                     out_valid_q;
	logic [103:0]             out_data_q;

	// Wrapped differences of the captured snapshots
	logic [COUNT_W-1:0] pd;
	logic [RB-1:0]      rd;
	always_comb begin
		if (pc_q < probe_last_q)
			pd = mask_q + COUNT_W'(1) - probe_last_q + pc_q;
		else
			pd = pc_q - probe_last_q;
		rd = rc_q - ref_last_q;
	end

	// Shared multiplier operand selection
	logic [COUNT_W-1:0]  mul_a;
	logic [FACTOR_W-1:0] mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [FACTOR_W-1:0] ch_factor;
	always_comb begin
		ch_factor = ch_q ? FACTOR_W'(tps_q) : factor_q;
		mul_a     = '0;
		mul_b     = ch_factor;
		case (state_q)
			ST_UPD: begin
				mul_a = COUNT_W'(prescale_q);
				mul_b = FACTOR_W'(tps_q);
			end
			ST_MHI: begin
				mul_a = ch_q ? COUNT_W'(ref_sum_q >> WINDOW_LOG2)
					: COUNT_W'(probe_sum_q >> WINDOW_LOG2);
			end
			ST_MLO: begin
				mul_a = ch_q ? COUNT_W'(ref_sum_q[WINDOW_LOG2-1:0])
					: COUNT_W'(probe_sum_q[WINDOW_LOG2-1:0]);
			end
			default: ;
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// One restoring division step
	logic [IVL_W:0]   div_t;
	logic             div_ge;
	logic [IVL_W-1:0] rem_next;
	logic [HZ_W-1:0]  qd_next;
	logic [HZ_W-1:0]  hz_final;
	always_comb begin
		div_t    = {rem_q, qd_q[HZ_W-1]};
		div_ge   = div_t >= {1'b0, ivl_q};
		rem_next = div_ge ? IVL_W'(div_t - {1'b0, ivl_q}) : div_t[IVL_W-1:0];
		qd_next  = {qd_q[HZ_W-2:0], div_ge};
		hz_final = sat_q ? '1 : qd_next;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Sequencer and window update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			probe_last_q <= '0;
			ref_last_q   <= '0;
			probe_sum_q  <= '0;
			ref_sum_q    <= '0;
			slot_q       <= '0;
			ivl_q        <= IVL_W'(1);
			out_valid_q  <= 1'b0;
			ch_q         <= 1'b0;
			cnt_q        <= '0;
			for (int i = 0; i < WIN; i++) begin
				probe_hist_q[i] <= '0;
				ref_hist_q[i]   <= '0;
			end
		end else begin
			// The final state reloads the output register itself.
			if (out_valid_q && m_axis_tready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						pc_q    <= s_axis_tdata[COUNT_W-1:0];
						rc_q    <= RB'(s_axis_tdata[COUNT_W +: REF_IN_W]);
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// Slide the window and adapt the interval.
					probe_last_q         <= pc_q;
					ref_last_q           <= rc_q;
					probe_sum_q          <= probe_sum_q - PSW'(probe_hist_q[slot_q]) + PSW'(pd);
					ref_sum_q            <= ref_sum_q - RSW'(ref_hist_q[slot_q]) + RSW'(rd);
					probe_hist_q[slot_q] <= pd;
					ref_hist_q[slot_q]   <= rd;
					slot_q               <= slot_q + WINDOW_LOG2'(1);
					if (pd < DELTA_LOW && ivl_q < ivl_max_q)
						ivl_q <= ivl_q + IVL_W'(1);
					else if (pd > DELTA_HIGH && ivl_q > IVL_W'(1))
						ivl_q <= ivl_q - IVL_W'(1);
					pd_q     <= pd;
					factor_q <= mul_p[FACTOR_W-1:0];
					ch_q     <= 1'b0;
					state_q  <= ST_MHI;
				end
				ST_MHI: begin
					prod_q  <= mul_p;
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					acc_q   <= prod_q;
					prod_q  <= mul_p;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q   <= acc_q + (prod_q >> WINDOW_LOG2);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// A quotient that cannot fit in 32 bits saturates.
					sat_q   <= acc_q[PROD_W-1:HZ_W] >= (PROD_W-HZ_W)'(ivl_q);
					rem_q   <= acc_q[HZ_W +: IVL_W];
					qd_q    <= acc_q[HZ_W-1:0];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					qd_q  <= qd_next;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(HZ_W - 1)) begin
						if (ch_q) begin
							ref_hz_q <= hz_final;
							state_q  <= ST_DONE;
						end else begin
							probe_freq_q <= hz_final;
							ch_q         <= 1'b1;
							state_q      <= ST_MHI;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {ivl_q, pd_q, ref_hz_q, probe_freq_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
